// File: rtl/bpts_pkg.sv
// Package for the beacon push-to-talk transmit sequencer.
// Holds the request/response word types, state and register types and codes.
// No dependencies.
package bpts_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_CHECK   = 3'd1,
      MODE_KEY_ON  = 3'd2,
      MODE_TX      = 3'd3,
      MODE_KEY_OFF = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_INIT      = 3'd0,
      ST_RADIO_OK  = 3'd1,
      ST_RADIO_ERR = 3'd2,
      ST_FIX       = 3'd3,
      ST_WAIT_FIX  = 3'd4,
      ST_TX_ACTIVE = 3'd5,
      ST_TX_DONE   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CSR_RADIO_OK       = 3'd0,
      CSR_BEACON_INTERVAL = 3'd1,
      CSR_CHANNEL_WAIT   = 3'd2,
      CSR_KEY_ON_DELAY   = 3'd3,
      CSR_KEY_OFF_DELAY  = 3'd4
   } csr_index_type;

   localparam logic [31:0] BEACON_INTERVAL_RESET = 32'd60000;
   localparam logic [31:0] CHANNEL_WAIT_RESET    = 32'd10000;
   localparam logic [15:0] KEY_ON_DELAY_RESET    = 16'd300;
   localparam logic [15:0] KEY_OFF_DELAY_RESET   = 16'd100;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        channel_busy;
      logic        tx_done;
      logic        gps_fix;
      logic        frame_ok;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       key_line;
      logic       build_frame;
      logic       start_tx;
      logic       stop_tx;
      logic [2:0] status_code;
   } rsp_type;

   typedef struct packed {
      logic        radio_ok;
      logic [31:0] beacon_interval_ms;
      logic [31:0] channel_wait_ms;
      logic [15:0] key_on_delay_ms;
      logic [15:0] key_off_delay_ms;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] beacon_stamp;
      logic [31:0] phase_stamp;
      status_type  status;
      logic        key;
   } seq_state_type;

endpackage

// File: rtl/beacon_ptt_tx_sequencer.sv
// Top level of the beacon push-to-talk transmit sequencer.
// Instantiates bpts_step; uses bpts_pkg.
//
// Each request word is one poll (timestamp plus busy/done/fix/frame-ok flags)
// and yields exactly one response word: mode, key line, the build/start/stop
// pulses and the status code after that poll. The block takes one word per
// clock while no response stall holds it: the word is captured in an input
// register, then one pass of compare-and-branch logic (one 32-bit wrapping
// subtract and compare per stamp) updates the sequencer state and loads the
// response register in the same edge. The response register decouples the
// two sides, so a new word is accepted while a finished response waits; a
// stalled response holds both stages and raises req_stall. Configuration
// registers are written through the csr_ port, which is always ready; write
// them only while no poll is in flight. Indexes above 4 are ignored.
module beacon_ptt_tx_sequencer
   import bpts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);

   logic          in_valid_ff;
   req_type       in_word_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_type       rsp_in;
   cfg_type       cfg_ff;
   logic          out_open;
   logic          advance;

   // Response register can take a word when empty or being drained
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   bpts_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .req_word  (in_word_ff),
      .nxt_state (state_in),
      .rsp_word  (rsp_in)
   );

   // Input stage: capture a word whenever the stage is free or moving on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
   end

   // Result stage and sequencer state advance together
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff          <= 1'b0;
         state_ff.mode         <= MODE_IDLE;
         state_ff.beacon_stamp <= 32'd0;
         state_ff.phase_stamp  <= 32'd0;
         state_ff.status       <= ST_INIT;
         state_ff.key          <= 1'b0;
      end else begin
         if (out_open) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radio_ok           <= 1'b0;
         cfg_ff.beacon_interval_ms <= BEACON_INTERVAL_RESET;
         cfg_ff.channel_wait_ms    <= CHANNEL_WAIT_RESET;
         cfg_ff.key_on_delay_ms    <= KEY_ON_DELAY_RESET;
         cfg_ff.key_off_delay_ms   <= KEY_OFF_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIO_OK:        cfg_ff.radio_ok           <= csr_wdata[0];
            CSR_BEACON_INTERVAL: cfg_ff.beacon_interval_ms <= csr_wdata;
            CSR_CHANNEL_WAIT:    cfg_ff.channel_wait_ms    <= csr_wdata;
            CSR_KEY_ON_DELAY:    cfg_ff.key_on_delay_ms    <= csr_wdata[15:0];
            CSR_KEY_OFF_DELAY:   cfg_ff.key_off_delay_ms   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   // Key line is up exactly while keying, transmitting or unkeying
   a_key_matches_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.key == ((state_ff.mode == MODE_KEY_ON) || (state_ff.mode == MODE_TX)
                       || (state_ff.mode == MODE_KEY_OFF)))
      else $error("key line out of step with mode");

   // At most one control pulse per response word
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.build_frame, rsp_data_ff.start_tx,
                                 rsp_data_ff.stop_tx}))
      else $error("more than one pulse in a response word");

   // Building the frame always enters key-on with transmitting status
   a_build_enters_key_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.build_frame) |->
         ((rsp_data_ff.mode == MODE_KEY_ON) && (rsp_data_ff.status_code == ST_TX_ACTIVE)
          && rsp_data_ff.key_line))
      else $error("build pulse without key-on");
`endif

endmodule

// File: rtl/bpts_step.sv
// Next-state and response logic for one poll of the transmit sequencer.
// Purely combinational; uses bpts_pkg.
module bpts_step
   import bpts_pkg::*;
(
   input  seq_state_type cur_state,
   input  cfg_type       cfg,
   input  req_type       req_word,
   output seq_state_type nxt_state,
   output rsp_type       rsp_word
);

   logic [31:0] since_beacon;
   logic [31:0] since_phase;
   logic        build;
   logic        start;
   logic        stop;

   // Wrapping elapsed time against both stamps
   assign since_beacon = req_word.now_ms - cur_state.beacon_stamp;
   assign since_phase  = req_word.now_ms - cur_state.phase_stamp;

   always_comb begin
      nxt_state = cur_state;
      build     = 1'b0;
      start     = 1'b0;
      stop      = 1'b0;

      case (cur_state.mode)
         MODE_IDLE: begin
            if (!cfg.radio_ok) begin
               nxt_state.status = ST_RADIO_ERR;
            end else if (req_word.gps_fix) begin
               nxt_state.status = ST_FIX;
            end else begin
               nxt_state.status = ST_WAIT_FIX;
            end
            if (cfg.radio_ok && (since_beacon >= cfg.beacon_interval_ms)) begin
               nxt_state.mode        = MODE_CHECK;
               nxt_state.phase_stamp = req_word.now_ms;
            end
         end
         MODE_CHECK: begin
            if (!req_word.channel_busy) begin
               if (req_word.frame_ok) begin
                  build                 = 1'b1;
                  nxt_state.key         = 1'b1;
                  nxt_state.status      = ST_TX_ACTIVE;
                  nxt_state.mode        = MODE_KEY_ON;
                  nxt_state.phase_stamp = req_word.now_ms;
               end else begin
                  nxt_state.beacon_stamp = req_word.now_ms;
                  nxt_state.mode         = MODE_IDLE;
               end
            end else if (since_phase >= cfg.channel_wait_ms) begin
               // give up on a busy channel
               nxt_state.beacon_stamp = req_word.now_ms;
               nxt_state.mode         = MODE_IDLE;
            end
         end
         MODE_KEY_ON: begin
            if (since_phase >= {16'd0, cfg.key_on_delay_ms}) begin
               start          = 1'b1;
               nxt_state.mode = MODE_TX;
            end
         end
         MODE_TX: begin
            if (req_word.tx_done) begin
               stop                  = 1'b1;
               nxt_state.status      = ST_TX_DONE;
               nxt_state.mode        = MODE_KEY_OFF;
               nxt_state.phase_stamp = req_word.now_ms;
            end
         end
         MODE_KEY_OFF: begin
            if (since_phase >= {16'd0, cfg.key_off_delay_ms}) begin
               nxt_state.key          = 1'b0;
               nxt_state.beacon_stamp = req_word.now_ms;
               nxt_state.mode         = MODE_IDLE;
            end
         end
         default: begin
            nxt_state.mode = MODE_IDLE;
         end
      endcase

      rsp_word.mode        = nxt_state.mode;
      rsp_word.key_line    = nxt_state.key;
      rsp_word.build_frame = build;
      rsp_word.start_tx    = start;
      rsp_word.stop_tx     = stop;
      rsp_word.status_code = nxt_state.status;
   end

endmodule
